@@ sv/mtep_pkg.sv @@
// Shared types and constants for the MIDI track event parser.
// No dependencies; imported by midi_track_event_parser.
package mtep_pkg;

  // Width of the running absolute tick count (wraps at this many bits)
  localparam int TIME_WIDTH = 32;
  // Width of the event_time port
  localparam int EVT_TIME_W = 32;
  // Width of the payload byte counter
  localparam int REMAIN_W   = 28;
  localparam int VLQ_W      = 32;

  localparam logic [REMAIN_W-1:0] REMAIN_MAX = {REMAIN_W{1'b1}};

  // Status bytes and masks
  localparam logic [7:0] STATUS_META  = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX = 8'hF0;
  localparam logic [7:0] HI_NIBBLE    = 8'hF0;
  localparam logic [7:0] STATUS_PROG  = 8'hC0;
  localparam logic [7:0] STATUS_PRESS = 8'hD0;
  localparam logic [7:0] VLQ_DATA     = 8'h7F;

  // Byte roles
  localparam logic [2:0] ROLE_DELTA  = 3'd0;
  localparam logic [2:0] ROLE_STATUS = 3'd1;
  localparam logic [2:0] ROLE_MTYPE  = 3'd2;
  localparam logic [2:0] ROLE_LENGTH = 3'd3;
  localparam logic [2:0] ROLE_DATA   = 3'd4;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_META    = 2'd1,
    KIND_SYSEX   = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    PH_DELTA     = 6'b000001,
    PH_STATUS    = 6'b000010,
    PH_META_TYPE = 6'b000100,
    PH_LENGTH    = 6'b001000,
    PH_PAYLOAD   = 6'b010000,
    PH_CHAN_DATA = 6'b100000
  } phase_t;

endpackage

@@ sv/midi_track_event_parser.sv @@
// Byte labeller for the body of a MIDI track chunk.
// Depends on mtep_pkg (types, roles, status constants).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one track byte per word, with
//   last_of_track high on the final byte of the track. Output channel
//   (out_valid/out_ready) returns one labelled word per input word: the byte
//   itself, its role, the event kind, the absolute tick time, and start/end
//   flags for the event.
//   The word is held in the input register, then the parser state update and
//   labelling logic loads the result register, which raises out_valid.
//   Throughput is one word per cycle while the receiver does not stall; the
//   limit is the combinational parser state update (7-bit shift-in plus
//   32-bit tick add).
//   The block takes a new word while a result waits as long as that word has
//   somewhere to go; when the receiver stalls, the result register and the
//   input register both hold, and in_ready drops once both are full.
//   Reset clears both stages and returns the parser to expecting a delta
//   time at tick zero. A word flagged last_of_track is labelled normally and
//   then returns the parser to that same reset state.
module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  track_byte,
  input  logic        last_of_track,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  byte_echo,
  output logic [2:0]  byte_role,
  output logic [1:0]  event_kind,
  output logic [31:0] event_time,
  output logic        event_start,
  output logic        event_end
);
  import mtep_pkg::*;

  // Input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_last;

  // Parser state
  phase_t                phase, phase_next;
  logic [TIME_WIDTH-1:0] tick_total, tick_total_next;
  logic [VLQ_W-1:0]      vlq_acc, vlq_acc_next;
  logic [REMAIN_W-1:0]   remain, remain_next;
  kind_t                 cur_kind, cur_kind_next;

  // Labelling results
  logic [2:0] role_c;
  kind_t      kind_c;
  logic       start_c;
  logic       end_c;

  logic             advance;
  logic             out_load;
  logic [VLQ_W-1:0] vlq_shifted;
  logic [REMAIN_W-1:0] len_sat;
  logic [REMAIN_W-1:0] remain_dec;

  // Move a word forward when the result register is free or draining
  assign out_load = !out_valid || out_ready;
  assign advance  = in_q_valid && out_load;
  assign in_ready = !in_q_valid || out_load;

  // Hold the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_q_byte <= track_byte;
      in_q_last <= last_of_track;
    end
  end

  // Shared arithmetic for variable-length counts and payload countdown
  assign vlq_shifted = (vlq_acc << 7) + VLQ_W'(in_q_byte & VLQ_DATA);
  assign len_sat     = (vlq_shifted > VLQ_W'(REMAIN_MAX)) ? REMAIN_MAX
                                                          : vlq_shifted[REMAIN_W-1:0];
  assign remain_dec  = (remain != '0) ? remain - REMAIN_W'(1) : '0;

  // Label the byte and step the parser
  always_comb begin
    phase_next      = phase;
    tick_total_next = tick_total;
    vlq_acc_next    = vlq_acc;
    remain_next     = remain;
    cur_kind_next   = cur_kind;
    role_c          = ROLE_DELTA;
    kind_c          = KIND_CHANNEL;
    start_c         = 1'b0;
    end_c           = 1'b0;

    unique case (phase)
      PH_STATUS: begin
        role_c       = ROLE_STATUS;
        start_c      = 1'b1;
        vlq_acc_next = '0;
        if (in_q_byte == STATUS_META) begin
          cur_kind_next = KIND_META;
          phase_next    = PH_META_TYPE;
        end else if (in_q_byte == STATUS_SYSEX) begin
          cur_kind_next = KIND_SYSEX;
          phase_next    = PH_LENGTH;
        end else begin
          cur_kind_next = KIND_CHANNEL;
          if ((in_q_byte & HI_NIBBLE) == STATUS_PROG ||
              (in_q_byte & HI_NIBBLE) == STATUS_PRESS) begin
            remain_next = REMAIN_W'(1);
          end else begin
            remain_next = REMAIN_W'(2);
          end
          phase_next = PH_CHAN_DATA;
        end
        kind_c = cur_kind_next;
      end
      PH_META_TYPE: begin
        role_c       = ROLE_MTYPE;
        kind_c       = cur_kind;
        vlq_acc_next = '0;
        phase_next   = PH_LENGTH;
      end
      PH_LENGTH: begin
        role_c       = ROLE_LENGTH;
        kind_c       = cur_kind;
        vlq_acc_next = vlq_shifted;
        if (!in_q_byte[7]) begin
          remain_next  = len_sat;
          vlq_acc_next = '0;
          if (len_sat == '0) begin
            end_c      = 1'b1;
            phase_next = PH_DELTA;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD, PH_CHAN_DATA: begin
        role_c      = ROLE_DATA;
        kind_c      = cur_kind;
        remain_next = remain_dec;
        if (remain_dec == '0) begin
          end_c      = 1'b1;
          phase_next = PH_DELTA;
        end
      end
      default: begin
        // Delta time: accumulate, add to the running total on the last byte
        vlq_acc_next = vlq_shifted;
        if (!in_q_byte[7]) begin
          tick_total_next = tick_total + TIME_WIDTH'(vlq_shifted);
          vlq_acc_next    = '0;
          phase_next      = PH_STATUS;
        end
      end
    endcase
  end

  // Update parser state; drop everything after the last byte of a track
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DELTA;
      tick_total <= '0;
      vlq_acc    <= '0;
      remain     <= '0;
      cur_kind   <= KIND_CHANNEL;
    end else if (advance) begin
      if (in_q_last) begin
        phase      <= PH_DELTA;
        tick_total <= '0;
        vlq_acc    <= '0;
        remain     <= '0;
        cur_kind   <= KIND_CHANNEL;
      end else begin
        phase      <= phase_next;
        tick_total <= tick_total_next;
        vlq_acc    <= vlq_acc_next;
        remain     <= remain_next;
        cur_kind   <= cur_kind_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_q_valid;
    end
    if (advance) begin
      byte_echo   <= in_q_byte;
      byte_role   <= role_c;
      event_kind  <= kind_c;
      event_time  <= EVT_TIME_W'(tick_total_next);
      event_start <= start_c;
      event_end   <= end_c;
    end
  end

  // A start flag only ever marks a status byte
  a_start_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_start |-> byte_role == ROLE_STATUS)
    else $error("event_start on a non-status byte");

  // An event only ends on a length byte or a data byte
  a_end_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_end |-> byte_role == ROLE_LENGTH || byte_role == ROLE_DATA)
    else $error("event_end on a byte that cannot close an event");

  // Delta bytes always report channel kind
  a_delta_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == ROLE_DELTA |-> event_kind == KIND_CHANNEL)
    else $error("delta byte with non-channel kind");

  // A meta type byte belongs to a meta event
  a_mtype_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == ROLE_MTYPE |-> event_kind == KIND_META)
    else $error("meta type byte outside a meta event");

  // The parser state moves only when a word is passed to the result stage
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase) && $stable(tick_total))
    else $error("parser state changed without a word advancing");

endmodule

@@ sim/tb_midi_track_event_parser.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for midi_track_event_parser: track byte streams in, labeled words out.
// Depends on mtep_pkg and the parser RTL; a scoreboard class predicts every labeled word.
module tb_midi_track_event_parser;
  import mtep_pkg::*;

  typedef struct packed {
    logic [7:0]            b;
    logic [2:0]            role;
    kind_t                 kind;
    logic [EVT_TIME_W-1:0] t;
    logic                  st;
    logic                  en;
  } labeled_word_t;

  class label_scoreboard;
    labeled_word_t         expected_q[$];
    phase_t                cur_phase;
    logic [TIME_WIDTH-1:0] ticks;
    logic [VLQ_W-1:0]      vlq;
    logic [REMAIN_W-1:0]   remaining;
    kind_t                 kind_now;
    int                    errors;
    int                    checked;

    function new();
      errors  = 0;
      checked = 0;
      clear_state();
    endfunction

    function void clear_state();
      cur_phase = PH_DELTA;
      ticks     = '0;
      vlq       = '0;
      remaining = '0;
      kind_now  = KIND_CHANNEL;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Label one accepted track byte and advance the parser state
    function void note_word(logic [7:0] b, logic last);
      labeled_word_t w;
      w      = '0;
      w.b    = b;
      w.kind = KIND_CHANNEL;
      case (cur_phase)
        PH_STATUS: begin
          w.role = ROLE_STATUS;
          w.st   = 1'b1;
          vlq    = '0;
          if (b == STATUS_META) begin
            kind_now  = KIND_META;
            cur_phase = PH_META_TYPE;
          end else if (b == STATUS_SYSEX) begin
            kind_now  = KIND_SYSEX;
            cur_phase = PH_LENGTH;
          end else begin
            kind_now  = KIND_CHANNEL;
            remaining = ((b & HI_NIBBLE) == STATUS_PROG || (b & HI_NIBBLE) == STATUS_PRESS) ?
                        REMAIN_W'(1) : REMAIN_W'(2);
            cur_phase = PH_CHAN_DATA;
          end
          w.kind = kind_now;
        end
        PH_META_TYPE: begin
          w.role    = ROLE_MTYPE;
          w.kind    = kind_now;
          vlq       = '0;
          cur_phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          w.role = ROLE_LENGTH;
          w.kind = kind_now;
          vlq    = (vlq << 7) + VLQ_W'(b & VLQ_DATA);
          if (!b[7]) begin
            // clamp the count to the width of the byte counter
            remaining = (vlq > VLQ_W'(REMAIN_MAX)) ? REMAIN_MAX : vlq[REMAIN_W-1:0];
            vlq       = '0;
            if (remaining == '0) begin
              w.en      = 1'b1;
              cur_phase = PH_DELTA;
            end else begin
              cur_phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD, PH_CHAN_DATA: begin
          w.role = ROLE_DATA;
          w.kind = kind_now;
          if (remaining != '0) remaining = remaining - REMAIN_W'(1);
          if (remaining == '0) begin
            w.en      = 1'b1;
            cur_phase = PH_DELTA;
          end
        end
        default: begin
          // delta time: shift in a group, add to the total on the final byte
          w.role = ROLE_DELTA;
          vlq    = (vlq << 7) + VLQ_W'(b & VLQ_DATA);
          if (!b[7]) begin
            ticks     = ticks + TIME_WIDTH'(vlq);
            vlq       = '0;
            cur_phase = PH_STATUS;
          end
        end
      endcase
      w.t = ticks[EVT_TIME_W-1:0];
      expected_q.push_back(w);
      if (last) clear_state();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Compare one labeled word against the oldest prediction
    task check_word(logic [7:0] b, logic [2:0] role, logic [1:0] kind,
                    logic [EVT_TIME_W-1:0] t, logic st, logic en);
      labeled_word_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("word %02h arrived with nothing pending", b));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (b !== e.b)
        report($sformatf("word %0d byte_echo %02h, want %02h", checked, b, e.b));
      if (role !== e.role)
        report($sformatf("word %0d byte_role %0d, want %0d", checked, role, e.role));
      if (kind !== e.kind)
        report($sformatf("word %0d event_kind %0d, want %0d", checked, kind, e.kind));
      if (t !== e.t)
        report($sformatf("word %0d event_time %08h, want %08h", checked, t, e.t));
      if (st !== e.st)
        report($sformatf("word %0d event_start %0b, want %0b", checked, st, e.st));
      if (en !== e.en)
        report($sformatf("word %0d event_end %0b, want %0b", checked, en, e.en));
    endtask
  endclass

  localparam int WORD_TARGET = 1500;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } stim_word_t;

  // Opening track: channel 3-byte and 2-byte events, max one-byte delta, zero-length sysex,
  // overlong wrapping delta, status without bit 7, then a saturated meta length cut by last
  localparam logic [7:0] DIRECTED_TRACK [0:27] = '{
    8'h00, 8'h90, 8'h3C, 8'h7F,
    8'h81, 8'h00, 8'hD5, 8'h12,
    8'h7F, STATUS_SYSEX, 8'h00,
    8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h3C, 8'h00, 8'hFF,
    8'h00, STATUS_META, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h41
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  track_byte;
  logic        last_of_track;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  byte_echo;
  logic [2:0]  byte_role;
  logic [1:0]  event_kind;
  logic [31:0] event_time;
  logic        event_start;
  logic        event_end;

  label_scoreboard sb = new();
  stim_word_t      word_q[$];
  bit              idle_on;
  bit              stall_on;
  int              cycles;
  int              words_sent;
  int              n_tracks;
  int              n_channel;
  int              n_meta;
  int              n_sysex;

  midi_track_event_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .track_byte    (track_byte),
    .last_of_track (last_of_track),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_echo     (byte_echo),
    .byte_role     (byte_role),
    .event_kind    (event_kind),
    .event_time    (event_time),
    .event_start   (event_start),
    .event_end     (event_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Note every accepted input word, check every accepted output word
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_word(track_byte, last_of_track);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(byte_echo, byte_role, event_kind, event_time, event_start, event_end);
  end

  // Mostly short gaps, a few long ones, none at all when idling is off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the receiver at random
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (stall_on && $urandom_range(0, 99) < 20)
          hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
    end
  end

  function automatic void push_byte(logic [7:0] b);
    stim_word_t w;
    w.b    = b;
    w.last = 1'b0;
    word_q.push_back(w);
  endfunction

  function automatic void mark_last();
    stim_word_t w;
    w      = word_q.pop_back();
    w.last = 1'b1;
    word_q.push_back(w);
  endfunction

  // Encode a variable-length count in exactly nbytes groups, most significant first
  function automatic void push_vlq(logic [41:0] value, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) push_byte({(i != 0), value[7*i +: 7]});
  endfunction

  function automatic void push_delta();
    int          r;
    logic [41:0] v;
    r = $urandom_range(0, 99);
    v = 42'({$urandom, $urandom});
    if (r < 50)      push_vlq(42'(v[6:0]), 1);
    else if (r < 75) push_vlq(42'(v[13:0]), 2);
    else if (r < 85) push_vlq(42'(v[20:0]), 3);
    else if (r < 93) push_vlq(42'(v[27:0]), 4);
    else             push_vlq(v, $urandom_range(5, 6));
  endfunction

  // Length of a meta or sysex payload, sometimes padded with a leading empty group
  function automatic int push_length();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 15)      n = 0;
    else if (r < 85) n = $urandom_range(1, 8);
    else             n = $urandom_range(9, 300);
    if (n < 128 && $urandom_range(0, 9) == 0) push_vlq(42'(n), 2);
    else push_vlq(42'(n), (n < 128) ? 1 : 2);
    return n;
  endfunction

  function automatic void push_event();
    int         r;
    int         n;
    logic [7:0] st;
    push_delta();
    r = $urandom_range(0, 99);
    if (r < 60 || r >= 95) begin
      if (r < 60) st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      else if ($urandom_range(0, 1)) st = {1'b0, 7'($urandom)};
      else st = 8'($urandom_range(8'hF1, 8'hFE));
      push_byte(st);
      n = ((st & HI_NIBBLE) == STATUS_PROG || (st & HI_NIBBLE) == STATUS_PRESS) ? 1 : 2;
      n_channel++;
    end else if (r < 80) begin
      push_byte(STATUS_META);
      push_byte(8'($urandom));
      n = push_length();
      n_meta++;
    end else begin
      push_byte(STATUS_SYSEX);
      n = push_length();
      n_sysex++;
    end
    repeat (n) push_byte(8'($urandom));
  endfunction

  // One track: mostly whole events, ending cleanly, cut short, trailing noise,
  // with a saturated length, or pure noise
  function automatic void build_track();
    int          r;
    int          events;
    int          keep;
    logic [41:0] v;
    r = $urandom_range(0, 99);
    n_tracks++;
    if (r < 4) begin
      repeat ($urandom_range(1, 10)) push_byte(8'($urandom));
      mark_last();
      return;
    end
    events = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
    repeat (events - 1) push_event();
    if (r < 9) begin
      push_delta();
      if ($urandom_range(0, 1)) begin
        push_byte(STATUS_META);
        push_byte(8'($urandom));
      end else begin
        push_byte(STATUS_SYSEX);
      end
      v     = 42'({$urandom, $urandom});
      v[28] = 1'b1;
      push_vlq(v, 5);
      repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
      mark_last();
      return;
    end
    keep = word_q.size();
    push_event();
    r = $urandom_range(0, 99);
    if (r >= 75 && r < 90) begin
      keep = keep + $urandom_range(1, word_q.size() - keep);
      while (word_q.size() > keep) void'(word_q.pop_back());
    end else if (r >= 90) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
    end
    mark_last();
  endfunction

  // Send the pending words; valid stays up across back-to-back words
  task automatic drive_track();
    int gap;
    for (int i = 0; i < word_q.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid      <= 1'b1;
      track_byte    <= word_q[i].b;
      last_of_track <= word_q[i].last;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      words_sent++;
    end
    word_q.delete();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    track_byte    = 8'h00;
    last_of_track = 1'b0;
    idle_on       = 1'b1;
    stall_on      = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_TRACK[i]) push_byte(DIRECTED_TRACK[i]);
    mark_last();
    drive_track();

    // Random tracks; some run with no idling on one or both sides
    while (words_sent < WORD_TARGET) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      build_track();
      drive_track();
    end
    in_valid <= 1'b0;

    // Drain the pending predictions, then watch for stray words
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d words in %0d random tracks plus one directed track", words_sent, n_tracks);
    $display("events: %0d channel, %0d meta, %0d sysex; %0d words checked, %0d mismatches",
             n_channel, n_meta, n_sysex, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
